@@ rtl/cpelt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpelt_pkg
// Shared constants and types of the contact pair enter/leave tracker.
// ----------------------------------------------------------------------------
package cpelt_pkg;

  localparam int PAIR_SLOTS = 16;
  localparam int ID_W       = 10;
  localparam int STAMP_W    = 16;
  localparam int LIMIT_W    = 4;

  // input commands
  localparam logic [1:0] CMD_CONTACT = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;

  // result kinds
  localparam logic [2:0] EV_DONE      = 3'd0;
  localparam logic [2:0] EV_COL_ENTER = 3'd1;
  localparam logic [2:0] EV_TRG_ENTER = 3'd2;
  localparam logic [2:0] EV_COL_LEAVE = 3'd3;
  localparam logic [2:0] EV_TRG_LEAVE = 3'd4;
  localparam logic [2:0] EV_FULL      = 3'd5;

  // cell operations
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_LOOK = 3'd1;
  localparam logic [2:0] OP_AGE  = 3'd2;
  localparam logic [2:0] OP_RMV  = 3'd3;
  localparam logic [2:0] OP_POP  = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic [ID_W-1:0]    p;
    logic [ID_W-1:0]    q;
    logic               trg;
    logic [STAMP_W-1:0] stamp;
    logic [LIMIT_W-1:0] limit;
    logic               any_match;
  } cell_req_t;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] first;
    logic [ID_W-1:0] second;
    logic            trg;
  } pair_bus_t;

endpackage

@@ rtl/cpelt_cell.sv @@
// ----------------------------------------------------------------------------
// cpelt_cell
// One table slot: pair, trigger flag, stamp and leave mark, with priority
// links to its lower and upper neighbours.
// ----------------------------------------------------------------------------
module cpelt_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cpelt_pkg::cell_req_t    req,
  input  logic                    match_in,
  output logic                    match_out,
  input  logic                    free_in,
  output logic                    free_out,
  input  cpelt_pkg::pair_bus_t    bus_in,
  output cpelt_pkg::pair_bus_t    bus_out
);

  logic                              valid_r, valid_nxt;
  logic                              mark_r, mark_nxt;
  logic [cpelt_pkg::ID_W-1:0]        first_r, second_r;
  logic                              trg_r;
  logic [cpelt_pkg::STAMP_W-1:0]     stamp_r;
  logic [cpelt_pkg::STAMP_W-1:0]     age;
  logic                              match, sel_match, sel_free, sel_mark, wr;

  assign match = valid_r && ((first_r == req.p && second_r == req.q) ||
                             (first_r == req.q && second_r == req.p));
  assign sel_match = match && !match_in;
  assign sel_free  = !valid_r && !free_in;
  assign sel_mark  = mark_r && !bus_in.hit;
  assign match_out = match_in || match;
  assign free_out  = free_in || !valid_r;
  assign wr        = (req.op == cpelt_pkg::OP_LOOK) && !req.any_match && sel_free;
  assign age       = req.stamp - stamp_r;

  // pass the lowest marked pair up the row
  always_comb begin
    bus_out = bus_in;
    if (sel_mark) begin
      bus_out.hit    = 1'b1;
      bus_out.first  = first_r;
      bus_out.second = second_r;
      bus_out.trg    = trg_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    mark_nxt  = mark_r;
    unique case (req.op)
      cpelt_pkg::OP_LOOK: if (wr) valid_nxt = 1'b1;
      cpelt_pkg::OP_AGE:  mark_nxt = valid_r &&
                                     (age > {{(cpelt_pkg::STAMP_W-cpelt_pkg::LIMIT_W){1'b0}},
                                             req.limit});
      cpelt_pkg::OP_RMV:  mark_nxt = valid_r && (first_r == req.p || second_r == req.p);
      cpelt_pkg::OP_POP: begin
        if (sel_mark) begin
          mark_nxt  = 1'b0;
          valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      first_r  <= req.p;
      second_r <= req.q;
      trg_r    <= req.trg;
    end
    if (wr || (req.op == cpelt_pkg::OP_LOOK && sel_match)) begin
      stamp_r <= req.stamp;
    end
  end

endmodule

@@ rtl/contact_pair_enter_leave_tracker.sv @@
// ----------------------------------------------------------------------------
// contact_pair_enter_leave_tracker
// Tracks active collider pairs in a row of slot cells and reports enter and
// leave events per contact report, frame tick or collider removal.
// ----------------------------------------------------------------------------
// channel | direction | tdata (low bit up)                         | tuser
// in_     | slave     | first_id, second_id, first_is_trigger,     | command
//         |           | second_is_trigger, touching, pad to 24     |
// out_    | master    | receiver_id, other_id, pad to 24           | event_kind
// cfg_    | write     | absent_limit                               | -
//
// A touching contact report is looked up in the cell row and, when its pair
// is new, gives two enter results; a report that does not touch or an
// unknown command gives only its result; a tick or removal marks pairs and
// then gives two leave results per retired pair. Every result passes through
// the single result register. The pair search runs combinationally across
// the cell row. Reset clears the table at once. A stalled result holds the
// sequencer; a new item is taken only once the previous is done.
module contact_pair_enter_leave_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // first_id, second_id, first_is_trigger,
                                  // second_is_trigger, touching, zero pad
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // receiver_id, other_id, zero pad
  output logic [2:0]  out_tuser,  // event_kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  localparam int N  = cpelt_pkg::PAIR_SLOTS;
  localparam int IW = cpelt_pkg::ID_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOOK = 4'd1;
  localparam logic [3:0] S_ENT0 = 4'd2;
  localparam logic [3:0] S_ENT1 = 4'd3;
  localparam logic [3:0] S_MARK = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_LV1  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_FULL = 4'd8;

  logic [3:0]                      state_r, state_nxt;
  logic [cpelt_pkg::LIMIT_W-1:0]   limit_r;
  logic [cpelt_pkg::STAMP_W-1:0]   frame_r;
  logic [1:0]                      cmd_r;
  logic [IW-1:0]                   p_r, q_r, lv_a_r, lv_b_r;
  logic                            trg_r, lv_trg_r;
  logic                            ovld_r;
  logic [2:0]                      okind_r;
  logic [IW-1:0]                   orx_r, oother_r;
  logic                            olast_r;
  logic                            can_emit, in_acc;
  logic                            emit;
  logic [2:0]                      e_kind;
  logic [IW-1:0]                   e_rx, e_other;
  logic                            e_last;
  cpelt_pkg::cell_req_t            req;
  logic [N:0]                      match_c, free_c;
  cpelt_pkg::pair_bus_t            bus_c [N+1];

  logic [IW-1:0] a_in, b_in;
  logic          ta_in, tb_in, touch_in;
  assign a_in     = in_tdata[IW-1:0];
  assign b_in     = in_tdata[2*IW-1:IW];
  assign ta_in    = in_tdata[2*IW];
  assign tb_in    = in_tdata[2*IW+1];
  assign touch_in = in_tdata[2*IW+2];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign can_emit  = !ovld_r || out_tready;

  assign match_c[0] = 1'b0;
  assign free_c[0]  = 1'b0;
  assign bus_c[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    cpelt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req),
      .match_in  (match_c[i]),
      .match_out (match_c[i+1]),
      .free_in   (free_c[i]),
      .free_out  (free_c[i+1]),
      .bus_in    (bus_c[i]),
      .bus_out   (bus_c[i+1])
    );
  end

  always_comb begin
    req           = '0;
    req.p         = p_r;
    req.q         = q_r;
    req.trg       = trg_r;
    req.stamp     = frame_r;
    req.limit     = limit_r;
    req.any_match = match_c[N];
    state_nxt     = state_r;
    emit          = 1'b0;
    e_kind        = cpelt_pkg::EV_DONE;
    e_rx          = '0;
    e_other       = '0;
    e_last        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            cpelt_pkg::CMD_CONTACT: state_nxt = touch_in ? S_LOOK : S_DONE;
            cpelt_pkg::CMD_TICK,
            cpelt_pkg::CMD_REMOVE:  state_nxt = S_MARK;
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_LOOK: begin
        req.op = cpelt_pkg::OP_LOOK;
        if (match_c[N])      state_nxt = S_DONE;
        else if (!free_c[N]) state_nxt = S_FULL;
        else                 state_nxt = S_ENT0;
      end
      S_ENT0, S_ENT1: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = trg_r ? cpelt_pkg::EV_TRG_ENTER : cpelt_pkg::EV_COL_ENTER;
          e_rx      = (state_r == S_ENT0) ? p_r : q_r;
          e_other   = (state_r == S_ENT0) ? q_r : p_r;
          state_nxt = (state_r == S_ENT0) ? S_ENT1 : S_DONE;
        end
      end
      S_MARK: begin
        req.op    = (cmd_r == cpelt_pkg::CMD_TICK) ? cpelt_pkg::OP_AGE : cpelt_pkg::OP_RMV;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!bus_c[N].hit) begin
          state_nxt = S_DONE;
        end else if (can_emit) begin
          req.op    = cpelt_pkg::OP_POP;
          emit      = 1'b1;
          e_kind    = bus_c[N].trg ? cpelt_pkg::EV_TRG_LEAVE : cpelt_pkg::EV_COL_LEAVE;
          e_rx      = bus_c[N].first;
          e_other   = bus_c[N].second;
          state_nxt = S_LV1;
        end
      end
      S_LV1: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = lv_trg_r ? cpelt_pkg::EV_TRG_LEAVE : cpelt_pkg::EV_COL_LEAVE;
          e_rx      = lv_b_r;
          e_other   = lv_a_r;
          state_nxt = S_SCAN;
        end
      end
      S_DONE, S_FULL: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_last    = 1'b1;
          e_kind    = (state_r == S_FULL) ? cpelt_pkg::EV_FULL : cpelt_pkg::EV_DONE;
          e_rx      = (state_r == S_FULL) ? p_r : '0;
          e_other   = (state_r == S_FULL) ? q_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= 4'd1;
      frame_r <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      // stamp advances before the age test
      if (in_acc && in_tuser == cpelt_pkg::CMD_TICK) frame_r <= frame_r + 1'b1;
      if (emit)            ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
      trg_r <= ta_in | tb_in;
      // trigger side first; a removal keeps its collider in p
      p_r   <= (in_tuser == cpelt_pkg::CMD_CONTACT && tb_in) ? b_in : a_in;
      q_r   <= (in_tuser == cpelt_pkg::CMD_CONTACT && tb_in) ? a_in : b_in;
    end
    if (state_r == S_SCAN) begin
      lv_a_r   <= bus_c[N].first;
      lv_b_r   <= bus_c[N].second;
      lv_trg_r <= bus_c[N].trg;
    end
    if (emit) begin
      okind_r  <= e_kind;
      orx_r    <= e_rx;
      oother_r <= e_other;
      olast_r  <= e_last;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {4'b0, oother_r, orx_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule

@@ rtl/cpelt_checker.sv @@
// ----------------------------------------------------------------------------
// cpelt_checker
// Port-level checks of the tracker's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cpelt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new transfer taken before the previous finished");

  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == cpelt_pkg::EV_DONE ||
                                 out_tuser == cpelt_pkg::EV_FULL))
    else $error("last result is not done or table full");

  a_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tuser != cpelt_pkg::EV_DONE &&
                                  out_tuser != cpelt_pkg::EV_FULL))
    else $error("terminal kind without last");

endmodule

bind contact_pair_enter_leave_tracker cpelt_checker u_cpelt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
